@@ hdl/smpen_pkg.sv @@
// shared types, constants and helpers for the sphere/mesh penetration unit
package smpen_pkg;

  // item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register index of triangles_in_use
  localparam logic REG_TRI_USE = 1'b0;

  // slot that selects the face normal
  localparam logic [1:0] SLOT_NORMAL = 2'd3;

  // fractional bits of the Q16.16 format
  localparam int unsigned FRAC_BITS = 16;

  // last sub-step of a three-component group and of an edge test
  localparam logic [3:0] SUB_LAST_VEC  = 4'd2;
  localparam logic [3:0] SUB_LAST_EDGE = 4'd8;
  localparam logic [1:0] EDGE_LAST     = 2'd2;

  // internal accumulator width
  localparam int unsigned ACC_W = 52;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -52'sd2147483648;

  // work groups of one triangle
  typedef enum logic [1:0] {
    GRP_DIST,
    GRP_PROJ,
    GRP_EDGE,
    GRP_SUM
  } grp_e;

  // controller to datapath
  typedef struct packed {
    logic       wr;
    logic       start;
    logic       rd;
    logic [1:0] rd_slot;
    logic       mul;
    logic       acc;
    grp_e       grp;
    logic [3:0] sub;
    logic [1:0] eidx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic below;
  } dp_stat_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(x);
    end
    return r;
  endfunction

endpackage

@@ hdl/sphere_mesh_penetration_unit.sv @@
// sphere against triangle mesh penetration unit: top level
// write item: taken back to back while idle
// query: walks the triangles in use; those close enough to the plane get the edge
// tests and those missing it are dropped; the single shared 32x32 multiplier
// sets the rate; one query at a time
// reset clears the control state and triangles_in_use; mesh contents are unset
module sphere_mesh_penetration_unit import smpen_pkg::*; #(
  parameter int unsigned MAX_TRIANGLES = 64,
  parameter int unsigned COORD_WIDTH   = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: tri_index[5:0], slot[7:6], coord_x[39:8], coord_y[71:40],
  //        coord_z[103:72], radius[134:104], zero[135]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  // tuser: operation[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: push_x[31:0], push_y[63:32], push_z[95:64]
  output logic [95:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [IW-1:0]      tri_idx;
  logic               out_load, out_free;
  logic [6:0]         tri_use_q;
  logic               m_valid_q;
  logic [95:0]        m_data_q;
  logic signed [31:0] push_x, push_y, push_z;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRI_USE) ? {25'd0, tri_use_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_use_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TRI_USE)) begin
      tri_use_q <= pwdata[6:0];
    end
  end

  // output register
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {push_z, push_y, push_x};
    end
  end

  smpen_ctrl #(
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .operation_i (s_axis_tuser),
    .tri_use_i   (tri_use_q),
    .stat_i      (stat),
    .out_free_i  (out_free),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd),
    .tri_o       (tri_idx),
    .out_load_o  (out_load)
  );

  smpen_datapath #(
    .MAX_TRIANGLES(MAX_TRIANGLES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .tri_i     (tri_idx),
    .wr_tri_i  (s_axis_tdata[5:0]),
    .slot_i    (s_axis_tdata[7:6]),
    .coord_x_i (s_axis_tdata[39:8]),
    .coord_y_i (s_axis_tdata[71:40]),
    .coord_z_i (s_axis_tdata[103:72]),
    .radius_i  (s_axis_tdata[134:104]),
    .stat_o    (stat),
    .push_x_o  (push_x),
    .push_y_o  (push_y),
    .push_z_o  (push_z)
  );

endmodule

@@ hdl/smpen_datapath.sv @@
// mesh memory, shared multiplier and accumulators of the penetration unit
module smpen_datapath import smpen_pkg::*; #(
  parameter int unsigned MAX_TRIANGLES = 64,
  parameter int unsigned COORD_WIDTH   = 32,
  localparam int unsigned IW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1,
  localparam int unsigned CWE = (COORD_WIDTH < 32) ? COORD_WIDTH : 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [IW-1:0]       tri_i,
  input  logic [5:0]          wr_tri_i,
  input  logic [1:0]          slot_i,
  input  logic signed [31:0]  coord_x_i,
  input  logic signed [31:0]  coord_y_i,
  input  logic signed [31:0]  coord_z_i,
  input  logic [30:0]         radius_i,
  output dp_stat_t            stat_o,
  output logic signed [31:0]  push_x_o,
  output logic signed [31:0]  push_y_o,
  output logic signed [31:0]  push_z_o
);

  localparam int unsigned DEPTH = MAX_TRIANGLES * 4;

  logic [3*CWE-1:0]   mem [DEPTH];
  logic [3*CWE-1:0]   rdata_q;
  logic               rdv_q;
  logic [1:0]         rslot_q;

  logic signed [31:0] vreg_q [4][3];
  logic signed [31:0] p_q    [3];
  logic signed [31:0] q_q    [3];
  logic signed [31:0] c_q    [3];
  logic signed [31:0] sum_q  [3];
  logic [30:0]        r_q;
  logic signed [ACC_W-1:0] d_q;
  logic signed [ACC_W-1:0] eacc_q;
  logic signed [47:0] t_q;
  logic               ok_q;
  logic signed [63:0] prod_q;

  logic signed [31:0] opa, opb;
  logic signed [31:0] ev [3];
  logic signed [31:0] wv [3];
  logic [1:0]         bsel;
  logic signed [47:0] fx;
  logic signed [ACC_W-1:0] fxw, rw, eacc_end;
  logic signed [31:0] ds, pen;
  logic               wr_ok;

  // write range check
  assign wr_ok = (32'(wr_tri_i) < MAX_TRIANGLES);

  // mesh memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem[{IW'(wr_tri_i), slot_i}] <= {coord_z_i[CWE-1:0], coord_y_i[CWE-1:0],
                                       coord_x_i[CWE-1:0]};
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[{tri_i, cmd_i.rd_slot}];
    end
  end

  // read data tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q   <= 1'b0;
      rslot_q <= 2'd0;
    end else begin
      rdv_q   <= cmd_i.rd;
      rslot_q <= cmd_i.rd_slot;
    end
  end

  // edge vectors e = b - a and w = q - a
  assign bsel = (cmd_i.eidx == EDGE_LAST) ? 2'd0 : cmd_i.eidx + 2'd1;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ev[k] = sat32(ACC_W'(vreg_q[bsel][k]) - ACC_W'(vreg_q[cmd_i.eidx][k]));
      wv[k] = sat32(ACC_W'(q_q[k]) - ACC_W'(vreg_q[cmd_i.eidx][k]));
    end
  end

  // derived scalars
  assign rw  = ACC_W'($signed({1'b0, r_q}));
  assign ds  = sat32(d_q);
  assign pen = sat32(d_q - rw);
  assign fx  = prod_q[63:FRAC_BITS];
  assign fxw = ACC_W'(fx);
  assign eacc_end = eacc_q + fxw;
  assign stat_o.below = (d_q < rw);

  // multiplier operand selection
  always_comb begin
    opa = vreg_q[3][cmd_i.sub[1:0]];
    opb = ds;
    case (cmd_i.grp)
      GRP_DIST: begin
        opb = sat32(ACC_W'(p_q[cmd_i.sub[1:0]]) - ACC_W'(vreg_q[0][cmd_i.sub[1:0]]));
      end
      GRP_PROJ: begin
        opb = ds;
      end
      GRP_EDGE: begin
        case (cmd_i.sub)
          4'd0:    begin opa = ev[1]; opb = wv[2]; end
          4'd1:    begin opa = ev[2]; opb = wv[1]; end
          4'd2:    begin opa = ev[2]; opb = wv[0]; end
          4'd3:    begin opa = ev[0]; opb = wv[2]; end
          4'd4:    begin opa = ev[0]; opb = wv[1]; end
          4'd5:    begin opa = ev[1]; opb = wv[0]; end
          4'd6:    begin opa = c_q[0]; opb = vreg_q[3][0]; end
          4'd7:    begin opa = c_q[1]; opb = vreg_q[3][1]; end
          default: begin opa = c_q[2]; opb = vreg_q[3][2]; end
        endcase
      end
      default: begin
        opb = pen;
      end
    endcase
  end

  // vector capture, multiply and accumulate
  always_ff @(posedge clk_i) begin
    if (rdv_q) begin
      for (int k = 0; k < 3; k++) begin
        vreg_q[rslot_q][k] <= 32'($signed(rdata_q[k*CWE +: CWE]));
      end
    end
    if (cmd_i.start) begin
      p_q[0] <= coord_x_i;
      p_q[1] <= coord_y_i;
      p_q[2] <= coord_z_i;
      r_q    <= radius_i;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= 64'(opa) * 64'(opb);
    end
    if (cmd_i.acc) begin
      case (cmd_i.grp)
        GRP_DIST: begin
          if (cmd_i.sub == 4'd0) begin
            d_q  <= fxw;
            ok_q <= 1'b1;
          end else begin
            d_q <= d_q + fxw;
          end
        end
        GRP_PROJ: begin
          q_q[cmd_i.sub[1:0]] <= sat32(ACC_W'(p_q[cmd_i.sub[1:0]]) - fxw);
        end
        GRP_EDGE: begin
          case (cmd_i.sub)
            4'd0, 4'd2, 4'd4: t_q <= fx;
            4'd1, 4'd3, 4'd5: c_q[cmd_i.sub[2:1]] <= sat32(ACC_W'(t_q) - fxw);
            4'd6: eacc_q <= fxw;
            4'd7: eacc_q <= eacc_end;
            default: begin
              if (eacc_end <= 0) begin
                ok_q <= 1'b0;
              end
            end
          endcase
        end
        default: begin
          if (ok_q) begin
            sum_q[cmd_i.sub[1:0]] <= sat32(ACC_W'(sum_q[cmd_i.sub[1:0]]) + fxw);
          end
        end
      endcase
    end
  end

  assign push_x_o = sum_q[0];
  assign push_y_o = sum_q[1];
  assign push_z_o = sum_q[2];

endmodule

@@ hdl/smpen_ctrl.sv @@
// sequencer that walks the triangles and steps the shared multiplier
module smpen_ctrl import smpen_pkg::*; #(
  parameter int unsigned MAX_TRIANGLES = 64,
  localparam int unsigned IW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1,
  localparam int unsigned CNTW = $clog2(MAX_TRIANGLES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          operation_i,
  input  logic [6:0]    tri_use_i,
  input  dp_stat_t      stat_i,
  input  logic          out_free_i,
  output logic          in_ready_o,
  output dp_cmd_t       cmd_o,
  output logic [IW-1:0] tri_o,
  output logic          out_load_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [CNTW-1:0] tri_q, cnt_q, cnt_d;
  logic [2:0]      ld_q;
  grp_e            grp_q;
  logic [3:0]      sub_q;
  logic [1:0]      eidx_q;
  logic            ph_q;
  logic            accept, skip, last_tri;
  logic [3:0]      sub_last;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load_o = (state_q == ST_DONE) && out_free_i;
  assign tri_o      = tri_q[IW-1:0];
  assign last_tri   = (tri_q + CNTW'(1)) == cnt_q;
  assign sub_last   = (grp_q == GRP_EDGE) ? SUB_LAST_EDGE : SUB_LAST_VEC;

  // triangle count clamped to the mesh size
  assign cnt_d = (32'(tri_use_i) > MAX_TRIANGLES) ? CNTW'(MAX_TRIANGLES)
                                                  : CNTW'(tri_use_i);

  // sphere misses the plane: drop the triangle before projecting
  assign skip = (state_q == ST_STEP) && (grp_q == GRP_PROJ) && (sub_q == 4'd0) &&
                !ph_q && !stat_i.below;

  // datapath commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.wr      = accept && (operation_i == OP_WRITE);
    cmd_o.start   = accept && (operation_i == OP_QUERY);
    cmd_o.rd      = (state_q == ST_LOAD) && !ld_q[2];
    cmd_o.rd_slot = ld_q[1:0];
    cmd_o.mul     = (state_q == ST_STEP) && !ph_q && !skip;
    cmd_o.acc     = (state_q == ST_STEP) && ph_q;
    cmd_o.grp     = grp_q;
    cmd_o.sub     = sub_q;
    cmd_o.eidx    = eidx_q;
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tri_q   <= '0;
      cnt_q   <= '0;
      ld_q    <= '0;
      grp_q   <= GRP_DIST;
      sub_q   <= '0;
      eidx_q  <= '0;
      ph_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && (operation_i == OP_QUERY)) begin
            cnt_q <= cnt_d;
            tri_q <= '0;
            ld_q  <= '0;
            state_q <= (cnt_d == '0) ? ST_DONE : ST_LOAD;
          end
        end
        ST_LOAD: begin
          ld_q <= ld_q + 3'd1;
          if (ld_q[2]) begin
            state_q <= ST_STEP;
            grp_q   <= GRP_DIST;
            sub_q   <= '0;
            eidx_q  <= '0;
            ph_q    <= 1'b0;
          end
        end
        ST_STEP: begin
          if (skip || (ph_q && (grp_q == GRP_SUM) && (sub_q == sub_last))) begin
            // next triangle
            ph_q <= 1'b0;
            ld_q <= '0;
            if (last_tri) begin
              state_q <= ST_DONE;
            end else begin
              tri_q   <= tri_q + CNTW'(1);
              state_q <= ST_LOAD;
            end
          end else if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            if (sub_q != sub_last) begin
              sub_q <= sub_q + 4'd1;
            end else begin
              sub_q <= '0;
              case (grp_q)
                GRP_DIST: grp_q <= GRP_PROJ;
                GRP_PROJ: begin
                  grp_q  <= GRP_EDGE;
                  eidx_q <= '0;
                end
                GRP_EDGE: begin
                  if (eidx_q == EDGE_LAST) begin
                    grp_q <= GRP_SUM;
                  end else begin
                    eidx_q <= eidx_q + 2'd1;
                  end
                end
                default: grp_q <= GRP_DIST;
              endcase
            end
          end
        end
        default: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_tri_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD || state_q == ST_STEP) |-> (tri_q < cnt_q))
    else $error("triangle index beyond walked count");
  a_sub_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && grp_q != GRP_EDGE) |-> (sub_q <= SUB_LAST_VEC))
    else $error("sub-step beyond vector group");
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q != ST_IDLE))
    else $error("query accepted but sequencer idle");
`endif

endmodule
